FILE: hdl/cron_next_fire_search_core_macros.svh
// Assertion helpers for the cron next-fire search core.
`ifndef CRON_NEXT_FIRE_SEARCH_CORE_MACROS_SVH
`define CRON_NEXT_FIRE_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define CNFS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define CNFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cnfs_pkg.sv
`timescale 1ns / 1ps

package cnfs_pkg;

    localparam int MIN_W  = 60;
    localparam int HOUR_W = 24;
    localparam int DOM_W  = 31;
    localparam int MON_W  = 12;
    localparam int DOW_W  = 7;
    localparam int CFG_W  = 60;

    localparam logic [7:0] YEAR_LAST  = 8'd199;
    localparam logic [3:0] MON_LAST   = 4'd12;
    localparam logic [4:0] DAY_LAST   = 5'd31;
    localparam logic [2:0] WD_LAST    = 3'd6;
    localparam logic [2:0] WD_INVALID = 3'd7;
    localparam logic [5:0] MIN_COUNT  = 6'd60;
    localparam logic [4:0] HOUR_COUNT = 5'd24;

    // Configuration register indexes
    localparam logic [2:0] REG_MINUTE_MASK = 3'd0;
    localparam logic [2:0] REG_HOUR_MASK   = 3'd1;
    localparam logic [2:0] REG_DOM_MASK    = 3'd2;
    localparam logic [2:0] REG_MONTH_MASK  = 3'd3;
    localparam logic [2:0] REG_DOW_MASK    = 3'd4;
    localparam logic [2:0] REG_DOM_WILD    = 3'd5;
    localparam logic [2:0] REG_DOW_WILD    = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST_M,
        ST_FIRST_H,
        ST_SAME_M,
        ST_SAME_H,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] idx;
    } ffs_t;

    // Lowest set bit of a 60-bit word
    function automatic ffs_t ffs60(input logic [MIN_W-1:0] v);
        ffs_t r;
        r.hit = |v;
        r.idx = '0;
        for (int i = MIN_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                r.idx = 6'(i);
            end
        end
        return r;
    endfunction

    // Bits strictly above position x
    function automatic logic [MIN_W-1:0] above60(input logic [5:0] x);
        logic [MIN_W-1:0] r;
        for (int i = 0; i < MIN_W; i++) begin
            r[i] = (6'(i) > x);
        end
        return r;
    endfunction

    // February is always 28 days
    function automatic logic [4:0] month_len(input logic [3:0] mon);
        logic [4:0] r;
        case (mon) inside
            4'd2:                     r = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
            default:                  r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mod7(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        for (int i = 0; i < 6; i++) begin
            if (t >= 6'd7) begin
                t = t - 6'd7;
            end
        end
        return t[2:0];
    endfunction

endpackage

FILE: hdl/cron_next_fire_search_core.sv
`timescale 1ns / 1ps
// Cron schedule match and next-fire search.
// Configuration: cfg_we, cfg_index, cfg_data write one mask or wildcard flag per
// clock; write only while busy is low. All registers reset to all ones.
// Request: start_* fields are taken at a clock edge with start high and busy low.
// busy then stays high until the result is posted.
// Result: done pulses for exactly one cycle with matches_now, found and next_*;
// the receiver must take it in that cycle, it cannot hold the result off.
// found low means no later match up to year offset 199; next_* are then zero.
// Search: in the preparation states ST_FIRST_M, ST_FIRST_H, ST_SAME_M and
// ST_SAME_H, one shared 60-bit lowest-set-bit unit finds the first allowed
// minute and hour and the next ones on the start day; then the day walker
// steps one calendar day at a time, starting at day 1 of the start month and
// ending at the match or at the last day of year offset 199; done follows in
// the next cycle. With no allowed minute or hour, or start year past 199, no walk.
// One request is in flight at a time; busy drops as done rises, so the next
// request can be taken at the edge that ends the done cycle.
// Reset clears the sequencer and restores the all-ones schedule.
module cron_next_fire_search_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    output logic                      done,
    input  logic [7:0]                start_year,
    input  logic [3:0]                start_month,
    input  logic [4:0]                start_day,
    input  logic [4:0]                start_hour,
    input  logic [5:0]                start_minute,
    input  logic [2:0]                start_weekday,
    output logic                      matches_now,
    output logic                      found,
    output logic [7:0]                next_year,
    output logic [3:0]                next_month,
    output logic [4:0]                next_day,
    output logic [4:0]                next_hour,
    output logic [5:0]                next_minute,
    output logic [2:0]                next_weekday,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_index,
    input  logic [cnfs_pkg::CFG_W-1:0] cfg_data
);
    import cnfs_pkg::*;
    `include "cron_next_fire_search_core_macros.svh"

    // Schedule registers
    logic [MIN_W-1:0]  minute_mask_reg;
    logic [HOUR_W-1:0] hour_mask_reg;
    logic [DOM_W-1:0]  dom_mask_reg;
    logic [MON_W-1:0]  month_mask_reg;
    logic [DOW_W-1:0]  dow_mask_reg;
    logic              dom_wild_reg;
    logic              dow_wild_reg;

    state_t state_reg, state_next;

    // Request
    logic [7:0] sy_reg, sy_next;
    logic [3:0] sm_reg, sm_next;
    logic [4:0] sd_reg, sd_next;
    logic [4:0] sh_reg, sh_next;
    logic [5:0] smin_reg, smin_next;

    // Prepared minute and hour picks
    ffs_t       fm_reg, fm_next;
    ffs_t       fh_reg, fh_next;
    ffs_t       same_m_reg, same_m_next;
    logic       day_hit_reg, day_hit_next;
    logic [4:0] day_h_reg, day_h_next;
    logic [5:0] day_m_reg, day_m_next;

    // Day walker
    logic [7:0] y_reg, y_next;
    logic [3:0] mon_reg, mon_next;
    logic [4:0] day_reg, day_next;
    logic [2:0] wd_reg, wd_next;

    // Result
    logic       done_reg, done_next;
    logic       now_reg, now_next;
    logic       found_reg, found_next;
    logic [7:0] ny_reg, ny_next;
    logic [3:0] nmon_reg, nmon_next;
    logic [4:0] nday_reg, nday_next;
    logic [4:0] nh_reg, nh_next;
    logic [5:0] nmin_reg, nmin_next;
    logic [2:0] nwd_reg, nwd_next;

    logic       accept;
    logic [MIN_W-1:0] ffs_in;
    ffs_t       ffs_out;
    logic       abort;

    logic [2:0] sw7;
    logic       dm_now, wm_now, day_now, min_now, hour_now, mon_now;
    logic [3:0] smc;

    logic       month_ok, dm, wm, day_ok, is_later, is_same, cand_hit, last_day;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Shared lowest-set-bit unit
    always_comb
    begin
        case (state_reg)
            ST_FIRST_M: ffs_in = minute_mask_reg;
            ST_FIRST_H: ffs_in = {{(MIN_W-HOUR_W){1'b0}}, hour_mask_reg};
            ST_SAME_M:  ffs_in = minute_mask_reg & above60(smin_reg);
            ST_SAME_H:  ffs_in = {{(MIN_W-HOUR_W){1'b0}}, hour_mask_reg}
                                 & above60({1'b0, sh_reg});
            default:    ffs_in = '0;
        endcase
    end
    assign ffs_out = ffs60(ffs_in);

    // Match of the request time itself
    assign sw7      = (start_weekday == WD_INVALID) ? 3'd0 : start_weekday;
    assign dm_now   = (start_day != 5'd0) && dom_mask_reg[start_day - 5'd1];
    assign wm_now   = dow_mask_reg[sw7];
    assign min_now  = (start_minute < MIN_COUNT) && minute_mask_reg[start_minute];
    assign hour_now = (start_hour < HOUR_COUNT) && hour_mask_reg[start_hour];
    assign mon_now  = (start_month != 4'd0) && (start_month <= MON_LAST)
                      && month_mask_reg[start_month - 4'd1];
    always_comb
    begin
        if (!dom_wild_reg && !dow_wild_reg) begin
            day_now = dm_now || wm_now;
        end else if (!dom_wild_reg) begin
            day_now = dm_now;
        end else if (!dow_wild_reg) begin
            day_now = wm_now;
        end else begin
            day_now = 1'b1;
        end
    end
    assign smc = (start_month == 4'd0) ? 4'd1 :
                 ((start_month > MON_LAST) ? MON_LAST : start_month);

    // Candidate day check
    assign month_ok = month_mask_reg[mon_reg - 4'd1];
    assign dm       = dom_mask_reg[day_reg - 5'd1];
    assign wm       = dow_mask_reg[wd_reg];
    always_comb
    begin
        if (!dom_wild_reg && !dow_wild_reg) begin
            day_ok = dm || wm;
        end else if (!dom_wild_reg) begin
            day_ok = dm;
        end else if (!dow_wild_reg) begin
            day_ok = wm;
        end else begin
            day_ok = 1'b1;
        end
    end
    assign is_later = (y_reg != sy_reg) || (mon_reg > sm_reg)
                      || ((mon_reg == sm_reg) && (day_reg > sd_reg));
    assign is_same  = (y_reg == sy_reg) && (mon_reg == sm_reg) && (day_reg == sd_reg);
    assign cand_hit = month_ok && day_ok && (is_later || (is_same && day_hit_reg));
    assign last_day = (y_reg == YEAR_LAST) && (mon_reg == MON_LAST) && (day_reg == DAY_LAST);
    assign abort    = !fm_reg.hit || !fh_reg.hit || (sy_reg > YEAR_LAST);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (start) state_next = ST_FIRST_M;
            ST_FIRST_M: state_next = ST_FIRST_H;
            ST_FIRST_H: state_next = ST_SAME_M;
            ST_SAME_M:  state_next = ST_SAME_H;
            ST_SAME_H:  state_next = abort ? ST_IDLE : ST_WALK;
            ST_WALK:    if (cand_hit || last_day) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        sy_next      = sy_reg;
        sm_next      = sm_reg;
        sd_next      = sd_reg;
        sh_next      = sh_reg;
        smin_next    = smin_reg;
        fm_next      = fm_reg;
        fh_next      = fh_reg;
        same_m_next  = same_m_reg;
        day_hit_next = day_hit_reg;
        day_h_next   = day_h_reg;
        day_m_next   = day_m_reg;
        y_next       = y_reg;
        mon_next     = mon_reg;
        day_next     = day_reg;
        wd_next      = wd_reg;
        done_next    = 1'b0;
        now_next     = now_reg;
        found_next   = found_reg;
        ny_next      = ny_reg;
        nmon_next    = nmon_reg;
        nday_next    = nday_reg;
        nh_next      = nh_reg;
        nmin_next    = nmin_reg;
        nwd_next     = nwd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    sy_next   = start_year;
                    sm_next   = start_month;
                    sd_next   = start_day;
                    sh_next   = start_hour;
                    smin_next = start_minute;
                    now_next  = min_now && hour_now && mon_now && day_now;
                    // walk from day 1 of the start month, weekday counted back
                    y_next    = start_year;
                    mon_next  = smc;
                    day_next  = 5'd1;
                    wd_next   = mod7(6'(sw7) + 6'd36 - 6'(start_day));
                end
            end
            ST_FIRST_M: fm_next = ffs_out;
            ST_FIRST_H: fh_next = ffs_out;
            ST_SAME_M:  same_m_next = ffs_out;
            ST_SAME_H:
            begin
                if ((sh_reg < HOUR_COUNT) && hour_mask_reg[sh_reg] && same_m_reg.hit) begin
                    day_hit_next = 1'b1;
                    day_h_next   = sh_reg;
                    day_m_next   = same_m_reg.idx;
                end else if (ffs_out.hit) begin
                    day_hit_next = 1'b1;
                    day_h_next   = ffs_out.idx[4:0];
                    day_m_next   = fm_reg.idx;
                end else begin
                    day_hit_next = 1'b0;
                    day_h_next   = '0;
                    day_m_next   = '0;
                end
                if (abort) begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    ny_next    = '0;
                    nmon_next  = '0;
                    nday_next  = '0;
                    nh_next    = '0;
                    nmin_next  = '0;
                    nwd_next   = '0;
                end
            end
            ST_WALK:
            begin
                if (cand_hit) begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    ny_next    = y_reg;
                    nmon_next  = mon_reg;
                    nday_next  = day_reg;
                    nh_next    = is_later ? fh_reg.idx[4:0] : day_h_reg;
                    nmin_next  = is_later ? fm_reg.idx : day_m_reg;
                    nwd_next   = wd_reg;
                end else if (last_day) begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    ny_next    = '0;
                    nmon_next  = '0;
                    nday_next  = '0;
                    nh_next    = '0;
                    nmin_next  = '0;
                    nwd_next   = '0;
                end else begin
                    // advance one calendar day
                    wd_next = (wd_reg == WD_LAST) ? 3'd0 : wd_reg + 3'd1;
                    if (day_reg == month_len(mon_reg)) begin
                        day_next = 5'd1;
                        if (mon_reg == MON_LAST) begin
                            mon_next = 4'd1;
                            y_next   = y_reg + 8'd1;
                        end else begin
                            mon_next = mon_reg + 4'd1;
                        end
                    end else begin
                        day_next = day_reg + 5'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            done_reg        <= 1'b0;
            minute_mask_reg <= '1;
            hour_mask_reg   <= '1;
            dom_mask_reg    <= '1;
            month_mask_reg  <= '1;
            dow_mask_reg    <= '1;
            dom_wild_reg    <= 1'b1;
            dow_wild_reg    <= 1'b1;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_MINUTE_MASK: minute_mask_reg <= cfg_data[MIN_W-1:0];
                    REG_HOUR_MASK:   hour_mask_reg   <= cfg_data[HOUR_W-1:0];
                    REG_DOM_MASK:    dom_mask_reg    <= cfg_data[DOM_W-1:0];
                    REG_MONTH_MASK:  month_mask_reg  <= cfg_data[MON_W-1:0];
                    REG_DOW_MASK:    dow_mask_reg    <= cfg_data[DOW_W-1:0];
                    REG_DOM_WILD:    dom_wild_reg    <= cfg_data[0];
                    REG_DOW_WILD:    dow_wild_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        sy_reg      <= sy_next;
        sm_reg      <= sm_next;
        sd_reg      <= sd_next;
        sh_reg      <= sh_next;
        smin_reg    <= smin_next;
        fm_reg      <= fm_next;
        fh_reg      <= fh_next;
        same_m_reg  <= same_m_next;
        day_hit_reg <= day_hit_next;
        day_h_reg   <= day_h_next;
        day_m_reg   <= day_m_next;
        y_reg       <= y_next;
        mon_reg     <= mon_next;
        day_reg     <= day_next;
        wd_reg      <= wd_next;
        now_reg     <= now_next;
        found_reg   <= found_next;
        ny_reg      <= ny_next;
        nmon_reg    <= nmon_next;
        nday_reg    <= nday_next;
        nh_reg      <= nh_next;
        nmin_reg    <= nmin_next;
        nwd_reg     <= nwd_next;
    end

    assign done         = done_reg;
    assign matches_now  = now_reg;
    assign found        = found_reg;
    assign next_year    = ny_reg;
    assign next_month   = nmon_reg;
    assign next_day     = nday_reg;
    assign next_hour    = nh_reg;
    assign next_minute  = nmin_reg;
    assign next_weekday = nwd_reg;

    `CNFS_ASSERT_NEXT(a_accept_busy, accept, busy, "request accepted but core not busy")
    `CNFS_ASSERT_NOW(a_done_idle, done_reg, state_reg == ST_IDLE, "result posted while searching")
    `CNFS_ASSERT_NOW(a_miss_zero, done_reg && !found_reg,
        (ny_reg == 8'd0) && (nmon_reg == 4'd0) && (nday_reg == 5'd0) && (nwd_reg == 3'd0),
        "no match but result fields not cleared")
    `CNFS_ASSERT_NOW(a_walk_day, state_reg == ST_WALK,
        (day_reg != 5'd0) && (day_reg <= month_len(mon_reg)) && (wd_reg <= WD_LAST)
        && (y_reg <= YEAR_LAST), "day walker left the calendar")
    `CNFS_ASSERT_NOW(a_hit_range, done_reg && found_reg,
        (nh_reg < HOUR_COUNT) && (nmin_reg < MIN_COUNT) && (nmon_reg != 4'd0),
        "match outside time range")

endmodule
